[hw/rtl/basc_pkg.sv]
package basc_pkg;

  // contact classes
  localparam logic [1:0] CLS_NONE   = 2'd0;
  localparam logic [1:0] CLS_NEWLY  = 2'd1;
  localparam logic [1:0] CLS_INSIDE = 2'd2;
  localparam logic [1:0] CLS_CROSS  = 2'd3;

  localparam int unsigned EDGE_W = 34;
  localparam int unsigned RV_W   = 33;

  // edge selector: lower edge, centre, upper edge
  typedef enum logic [1:0] {
    SEL_LO  = 2'd0,
    SEL_MID = 2'd1,
    SEL_HI  = 2'd2
  } edge_sel_t;

  // pass-along flags for the classify stage
  typedef struct packed {
    logic       contain;
    logic       crossing;
    logic       dt_pos;
    logic       dt_zero;
    logic [31:0] dt_abs;
  } cls_info_t;

endpackage

[hw/rtl/basc_div.sv]
// Pipelined restoring divider, one quotient bit per stage, unsigned.
module basc_div
  import basc_pkg::*;
#(
  parameter int NUM_W = 64,
  parameter int DEN_W = 34,
  parameter int TAG_W = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_vld,
  input  logic [NUM_W-1:0] in_num,
  input  logic [DEN_W-1:0] in_den,
  input  logic [TAG_W-1:0] in_tag,
  output logic             out_vld,
  output logic [NUM_W-1:0] out_quo,
  output logic [TAG_W-1:0] out_tag
);

  localparam int R_W = DEN_W + 1;

  logic             vld_r [1:NUM_W];
  logic [NUM_W-1:0] quo_r [1:NUM_W];
  logic [R_W-1:0]   rem_r [1:NUM_W];
  logic [DEN_W-1:0] den_r [1:NUM_W];
  logic [TAG_W-1:0] tag_r [1:NUM_W];

  // each stage shifts one numerator bit into the remainder
  for (genvar s = 0; s < NUM_W; s++) begin : g_stage
    logic             vld_i;
    logic [NUM_W-1:0] quo_i;
    logic [R_W-1:0]   rem_i;
    logic [DEN_W-1:0] den_i;
    logic [TAG_W-1:0] tag_i;
    logic [R_W:0]   sh;
    logic [R_W:0]   diff;
    logic           ge;
    // first stage takes the input word, the rest take the previous stage
    if (s == 0) begin : g_head
      assign vld_i = in_vld;
      assign quo_i = in_num;
      assign rem_i = '0;
      assign den_i = in_den;
      assign tag_i = in_tag;
    end else begin : g_body
      assign vld_i = vld_r[s];
      assign quo_i = quo_r[s];
      assign rem_i = rem_r[s];
      assign den_i = den_r[s];
      assign tag_i = tag_r[s];
    end
    assign sh   = {rem_i, quo_i[NUM_W-1]};
    assign diff = sh - {2'b00, den_i};
    assign ge   = !diff[R_W];
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s+1] <= 1'b0;
      end else begin
        vld_r[s+1] <= vld_i;
      end
      rem_r[s+1] <= ge ? diff[R_W-1:0] : sh[R_W-1:0];
      quo_r[s+1] <= {quo_i[NUM_W-2:0], ge};
      den_r[s+1] <= den_i;
      tag_r[s+1] <= tag_i;
    end
  end

  assign out_vld = vld_r[NUM_W];
  assign out_quo = quo_r[NUM_W];
  assign out_tag = tag_r[NUM_W];

endmodule

[hw/rtl/box_axis_sweep_classifier.sv]
// Path from start to out_valid: edge select, gap, sign fold, a one-bit-per-stage divider,
//   then classify.
// Throughput: one word per cycle; busy is tied low, the divider pipeline sets latency.
// Reset: rst_n synchronous active low clears all valid bits; payload is not reset.
// The receiver cannot stall: each result shows for exactly one cycle with out_valid.
module box_axis_sweep_classifier
  import basc_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_obj_pos,
  input  logic        [30:0] in_obj_size,
  input  logic signed [31:0] in_obj_vel,
  input  logic signed [31:0] in_tar_pos,
  input  logic        [30:0] in_tar_size,
  input  logic signed [31:0] in_tar_vel,
  input  logic signed [31:0] in_delta_time,
  output logic               out_valid,
  output logic        [1:0]  out_contact_class,
  output logic signed [31:0] out_travel_time
);

  localparam int NUM_W = EDGE_W + FRAC_BITS;
  localparam int TAG_W = $bits(cls_info_t) + 1;

  assign busy = 1'b0;

  // stage 1: edges, containment, crossing, edge pick, relative velocity
  logic s1_vld_r;
  logic signed [EDGE_W-1:0] o_sel_r, t_sel_r;
  logic signed [RV_W-1:0]   rv_r;
  cls_info_t                s1_info_r;

  logic signed [EDGE_W-1:0] op2, tp2, os_e, ts_e, olo, ohi, tlo, thi;
  logic signed [1:0] tm, od, td, side, osel, tsel, sov, stv;
  logic faster, t_in_o, o_in_t, pick, pos_side, neg_side;
  logic [32:0] aov, atv;

  function automatic logic signed [1:0] sgn32(input logic signed [31:0] v);
    sgn32 = (v == 0) ? 2'sd0 : (v[31] ? -2'sd1 : 2'sd1);
  endfunction

  function automatic logic signed [EDGE_W-1:0] pick_edge(
    input logic signed [1:0] s, input logic signed [EDGE_W-1:0] lo,
    input logic signed [EDGE_W-1:0] mid, input logic signed [EDGE_W-1:0] hi);
    pick_edge = (s == 2'sd1) ? hi : ((s == -2'sd1) ? lo : mid);
  endfunction

  always_comb begin
    op2  = {{(EDGE_W-33){in_obj_pos[31]}}, in_obj_pos, 1'b0};
    tp2  = {{(EDGE_W-33){in_tar_pos[31]}}, in_tar_pos, 1'b0};
    os_e = {{(EDGE_W-31){1'b0}}, in_obj_size};
    ts_e = {{(EDGE_W-31){1'b0}}, in_tar_size};
    olo  = op2 - os_e;
    ohi  = op2 + os_e;
    tlo  = tp2 - ts_e;
    thi  = tp2 + ts_e;
    tm   = (!in_delta_time[31] && in_delta_time != 0) ? 2'sd1 : -2'sd1;
    sov  = sgn32(in_obj_vel);
    stv  = sgn32(in_tar_vel);
    od   = (tm == 2'sd1) ? sov : -sov;
    td   = (tm == 2'sd1) ? stv : -stv;
    aov  = in_obj_vel[31] ? -{in_obj_vel[31], in_obj_vel} : {1'b0, in_obj_vel};
    atv  = in_tar_vel[31] ? -{in_tar_vel[31], in_tar_vel} : {1'b0, in_tar_vel};
    faster = aov > atv;
    side = (in_obj_pos == in_tar_pos) ? 2'sd0 :
           ((in_obj_pos < in_tar_pos) ? 2'sd1 : -2'sd1);
    t_in_o = thi < ohi && tlo < ohi && thi > olo && tlo > olo;
    o_in_t = ohi < thi && olo < thi && ohi > tlo && olo > tlo;
    pick = 1'b0;
    osel = side;
    tsel = -side;
    if (o_in_t) begin
      if (od != td) begin
        osel = (od == 0) ? td : od;
        pick = 1'b1;
      end else if (od != 0) begin
        osel = faster ? od : -od;
        pick = 1'b1;
      end
    end else if (t_in_o) begin
      if (od != td) begin
        osel = (td == 0) ? od : td;
        pick = 1'b1;
      end else if (td != 0) begin
        osel = faster ? -td : td;
        pick = 1'b1;
      end
    end
    if (pick) begin
      tsel = osel;
    end
    pos_side = (tlo < ohi) != (thi < ohi);
    neg_side = (thi < olo) != (tlo < olo);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= start;
    end
    o_sel_r <= pick_edge(osel, olo, op2, ohi);
    t_sel_r <= pick_edge(tsel, tlo, tp2, thi);
    rv_r    <= RV_W'(in_obj_vel) - RV_W'(in_tar_vel);
    s1_info_r.contain  <= t_in_o || o_in_t;
    s1_info_r.crossing <= pos_side || neg_side;
    s1_info_r.dt_pos   <= !in_delta_time[31] && in_delta_time != 0;
    s1_info_r.dt_zero  <= in_delta_time == 0;
    s1_info_r.dt_abs   <= in_delta_time[31] ? 32'(-in_delta_time) : in_delta_time;
  end

  // stage 2: gap
  logic s2_vld_r;
  logic signed [EDGE_W:0] gap_r;
  logic signed [RV_W-1:0] rv2_r;
  cls_info_t              s2_info_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
    gap_r     <= (EDGE_W+1)'(t_sel_r) - (EDGE_W+1)'(o_sel_r);
    rv2_r     <= rv_r;
    s2_info_r <= s1_info_r;
  end

  // stage 3: magnitudes and quotient sign
  logic s3_vld_r, neg_r, rvz_r;
  logic [NUM_W-1:0]  num_r;
  logic [EDGE_W-1:0] den_r;
  cls_info_t         s3_info_r;
  logic [EDGE_W:0]   gap_abs;

  assign gap_abs = gap_r[EDGE_W] ? -gap_r : gap_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else begin
      s3_vld_r <= s2_vld_r;
    end
    num_r <= {gap_abs[EDGE_W-1:0], {FRAC_BITS{1'b0}}};
    den_r <= rv2_r[RV_W-1] ? {-rv2_r, 1'b0} : {rv2_r, 1'b0};
    neg_r <= gap_r[EDGE_W] ^ rv2_r[RV_W-1];
    rvz_r <= rv2_r == 0;
    s3_info_r <= s2_info_r;
  end

  // divider pipeline
  logic             dv_vld;
  logic [NUM_W-1:0] dv_quo;
  logic [TAG_W*1+1-1:0] dv_tag;
  basc_div #(.NUM_W(NUM_W), .DEN_W(EDGE_W), .TAG_W(TAG_W+1)) u_div (
    .clk(clk), .rst_n(rst_n), .in_vld(s3_vld_r), .in_num(num_r), .in_den(den_r),
    .in_tag({s3_info_r, neg_r, rvz_r}), .out_vld(dv_vld), .out_quo(dv_quo),
    .out_tag(dv_tag)
  );

  // final stage: sign, saturation, class
  cls_info_t fi;
  logic f_neg, f_rvz, ovf;
  logic signed [31:0] tt;
  logic [31:0] tt_abs;
  logic tt_pos, near, same;
  logic [1:0] cls;

  always_comb begin
    {fi, f_neg, f_rvz} = dv_tag;
    ovf = f_neg ? (dv_quo > NUM_W'(33'h80000000)) : (dv_quo > NUM_W'(32'h7FFFFFFF));
    if (f_rvz) begin
      tt = 32'sh7FFFFFFF;
    end else if (ovf) begin
      tt = f_neg ? 32'sh80000000 : 32'sh7FFFFFFF;
    end else begin
      tt = f_neg ? 32'(-dv_quo) : 32'(dv_quo);
    end
    tt_abs = tt[31] ? 32'(-tt) : tt;
    tt_pos = !tt[31] && tt != 0;
    near = (!fi.dt_zero && fi.dt_abs > tt_abs) || tt == 0;
    same = (fi.dt_zero && tt == 0) || (fi.dt_pos && tt_pos) ||
           (!fi.dt_zero && !fi.dt_pos && tt[31]);
    if (near && same) begin
      cls = CLS_NEWLY;
    end else if (fi.contain) begin
      cls = CLS_INSIDE;
    end else if (fi.crossing) begin
      cls = CLS_CROSS;
    end else begin
      cls = CLS_NONE;
    end
  end

  logic out_valid_r;
  logic [1:0] cls_r;
  logic signed [31:0] tt_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= dv_vld;
    end
    cls_r <= cls;
    tt_r  <= tt;
  end

  assign out_valid         = out_valid_r;
  assign out_contact_class = cls_r;
  assign out_travel_time   = tt_r;

  // zero relative velocity must give the maximum time
  assert property (@(posedge clk) disable iff (!rst_n)
    dv_vld && f_rvz |-> tt == 32'sh7FFFFFFF) else $error("rv zero tt");
  // valid bits walk through the front stages
  assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r |=> s2_vld_r) else $error("s2 valid lost");
  assert property (@(posedge clk) disable iff (!rst_n)
    s2_vld_r |=> s3_vld_r) else $error("s3 valid lost");
  assert property (@(posedge clk) disable iff (!rst_n)
    dv_vld |=> out_valid) else $error("out valid lost");

endmodule
